// File: rtl/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
// Command codes, register decode values, reset bases and the result record.
// No dependencies.
package bsm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CPU   = 2'd1,
    CMD_PPU   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  localparam logic [15:0] REG_DECODE_MASK  = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
  localparam logic [15:0] REG_MIRRORING    = 16'hA000;
  localparam logic [15:0] REG_IRQ_LATCH    = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD   = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

  localparam logic [2:0] MODE_PRG_8000 = 3'd6;
  localparam logic [2:0] MODE_PRG_A000 = 3'd7;

  localparam int          ROM_AW          = 20;
  localparam int          PRG_SLOTS       = 4;
  localparam int          CHR_SLOTS       = 8;
  localparam logic [5:0]  PRG_COUNT_RESET = 6'd2;
  localparam logic [7:0]  IRQ_RESET       = 8'hFF;
  localparam logic [19:0] PRG_PAIR_BYTES  = 20'h04000;

  // Reset bases for a count of two: last four 8 KB program banks, first eight
  // 1 KB character banks right after program ROM.
  localparam logic [19:0] PRG_BASE_RESET [PRG_SLOTS] = '{
    20'h00000, 20'h02000, 20'h04000, 20'h06000
  };
  localparam logic [19:0] CHR_BASE_RESET [CHR_SLOTS] = '{
    20'h08000, 20'h08400, 20'h08800, 20'h08C00,
    20'h09000, 20'h09400, 20'h09800, 20'h09C00
  };

  typedef struct packed {
    logic [ROM_AW-1:0] rom_address;
    logic              irq_request;
    logic              mirroring;
  } res_t;

endpackage

// File: rtl/bank_switch_mapper_with_scanline_irq_unit.sv
// Top level of the bank switch mapper with scanline interrupt counter.
// Depends on bsm_pkg for command codes, decode values and reset bases.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, address and data. Each
//   transfer is a register write, a CPU translate, a PPU translate or a
//   scanline tick, and yields exactly one result on the output channel
//   (out_valid / out_stall): rom_address, irq_request and mirroring.
//   A result is registered into the output register, or into the skid
//   register when the receiver stalls. Throughput is one item per cycle
//   while the receiver does not stall; all decode, bank update and address
//   add sit between the mapper state and the output register.
//   When the receiver stalls, the pending result holds in the output
//   register and one more input is taken into a skid register; in_stall
//   then rises until the skid entry drains.
//   cfg_wr_en / cfg_wr_data set the 16 KB program unit count. It is read
//   only when bank data is written, so bases already computed stay put.
//   Synchronous reset: count 2, last four 8 KB program banks and first eight
//   1 KB character banks mapped, IRQ counter and latch 255, IRQ enabled,
//   mirroring 0, both channels empty.
module bank_switch_mapper_with_scanline_irq_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [5:0]                cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [15:0]               address,
  input  logic [7:0]                data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bsm_pkg::ROM_AW-1:0] rom_address,
  output logic                      irq_request,
  output logic                      mirroring
);
  import bsm_pkg::*;

  logic [5:0]        prg_16k_bank_count;
  logic [7:0]        bank_select;
  logic [ROM_AW-1:0] prg_slot_base [PRG_SLOTS];
  logic [ROM_AW-1:0] chr_slot_base [CHR_SLOTS];
  logic [7:0]        irq_count;
  logic [7:0]        irq_latch;
  logic              reload_pending;
  logic              irq_enabled;
  logic              mirror_bit;

  logic [7:0]        bank_select_next;
  logic [ROM_AW-1:0] prg_slot_base_next [PRG_SLOTS];
  logic [ROM_AW-1:0] chr_slot_base_next [CHR_SLOTS];
  logic [7:0]        irq_count_next;
  logic [7:0]        irq_latch_next;
  logic              reload_pending_next;
  logic              irq_enabled_next;
  logic              mirror_bit_next;

  logic              accept;
  logic              take;
  res_t              res;
  res_t              out_res;
  res_t              skid_res;
  logic              skid_valid;

  logic [ROM_AW-1:0] chr_start;
  logic [ROM_AW-1:0] second_last;
  logic [7:0]        prg_mask;
  logic [7:0]        prg_masked;
  logic [ROM_AW-1:0] prg_base;
  logic [2:0]        mode;
  logic              chr_invert;
  logic              prg_swap;
  logic [2:0]        pair_slot;
  logic [2:0]        single_slot;
  logic [7:0]        pair_bank;
  logic [ROM_AW-1:0] pair_lo_base;
  logic [ROM_AW-1:0] pair_hi_base;
  logic [ROM_AW-1:0] single_base;
  logic [7:0]        tick_count;
  logic [15:0]       reg_code;

  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign chr_start    = {prg_16k_bank_count, 14'd0};
  assign second_last  = chr_start - PRG_PAIR_BYTES;
  assign prg_mask     = {1'b0, prg_16k_bank_count, 1'b0} - 8'd1;
  assign prg_masked   = data & prg_mask;
  assign prg_base     = {prg_masked[6:0], 13'd0};
  assign mode         = bank_select[2:0];
  assign chr_invert   = bank_select[7];
  assign prg_swap     = bank_select[6];
  assign pair_slot    = {chr_invert, mode[1:0] + mode[1:0]};
  assign single_slot  = mode + {chr_invert, 2'b10};
  assign pair_bank    = {data[7:1], 1'b0};
  assign pair_lo_base = chr_start + {2'd0, pair_bank, 10'd0};
  assign pair_hi_base = chr_start + {2'd0, pair_bank[7:1], 1'b1, 10'd0};
  assign single_base  = chr_start + {2'd0, data, 10'd0};
  assign tick_count   = reload_pending ? irq_latch : irq_count;
  assign reg_code     = address & REG_DECODE_MASK;

  always_comb begin
    bank_select_next    = bank_select;
    prg_slot_base_next  = prg_slot_base;
    chr_slot_base_next  = chr_slot_base;
    irq_count_next      = irq_count;
    irq_latch_next      = irq_latch;
    reload_pending_next = reload_pending;
    irq_enabled_next    = irq_enabled;
    mirror_bit_next     = mirror_bit;
    res.rom_address     = '0;
    res.irq_request     = 1'b0;

    unique case (cmd_t'(cmd))
      CMD_WRITE: begin
        unique case (reg_code)
          REG_BANK_SELECT: bank_select_next = data;
          REG_BANK_DATA: begin
            if (mode[2:1] == 2'b00) begin
              chr_slot_base_next[pair_slot]        = pair_lo_base;
              chr_slot_base_next[pair_slot | 3'd1] = pair_hi_base;
            end else if (mode == MODE_PRG_8000) begin
              if (prg_swap) begin
                prg_slot_base_next[0] = second_last;
                prg_slot_base_next[2] = prg_base;
              end else begin
                prg_slot_base_next[2] = second_last;
                prg_slot_base_next[0] = prg_base;
              end
            end else if (mode == MODE_PRG_A000) begin
              prg_slot_base_next[1] = prg_base;
            end else begin
              chr_slot_base_next[single_slot] = single_base;
            end
          end
          REG_MIRRORING:   mirror_bit_next = data[0];
          REG_IRQ_LATCH:   irq_latch_next = data;
          REG_IRQ_RELOAD: begin
            irq_count_next      = '0;
            reload_pending_next = 1'b1;
          end
          REG_IRQ_DISABLE: irq_enabled_next = 1'b0;
          REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
          default: ;
        endcase
      end
      CMD_CPU: begin
        res.rom_address = prg_slot_base[address[14:13]] + {7'd0, address[12:0]};
      end
      CMD_PPU: begin
        res.rom_address = chr_slot_base[address[12:10]] + {10'd0, address[9:0]};
      end
      CMD_TICK: begin
        reload_pending_next = 1'b0;
        if (tick_count != 8'd0) begin
          irq_count_next = tick_count - 8'd1;
        end else begin
          res.irq_request = irq_enabled;
          irq_count_next  = irq_latch;
        end
      end
      default: ;
    endcase

    res.mirroring = mirror_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_16k_bank_count <= PRG_COUNT_RESET;
    end else if (cfg_wr_en) begin
      prg_16k_bank_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select    <= '0;
      prg_slot_base  <= PRG_BASE_RESET;
      chr_slot_base  <= CHR_BASE_RESET;
      irq_count      <= IRQ_RESET;
      irq_latch      <= IRQ_RESET;
      reload_pending <= 1'b0;
      irq_enabled    <= 1'b1;
      mirror_bit     <= 1'b0;
    end else if (accept) begin
      bank_select    <= bank_select_next;
      prg_slot_base  <= prg_slot_base_next;
      chr_slot_base  <= chr_slot_base_next;
      irq_count      <= irq_count_next;
      irq_latch      <= irq_latch_next;
      reload_pending <= reload_pending_next;
      irq_enabled    <= irq_enabled_next;
      mirror_bit     <= mirror_bit_next;
    end
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || take) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rom_address = out_res.rom_address;
  assign irq_request = out_res.irq_request;
  assign mirroring   = out_res.mirroring;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output result");

  a_irq_reload: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_WRITE) && ((address & REG_DECODE_MASK) == REG_IRQ_RELOAD)
    |=> reload_pending && (irq_count == 8'd0))
    else $error("irq reload write did not arm the reload");

  a_tick_decrement: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_TICK) && !reload_pending && (irq_count != 8'd0)
    |=> irq_count == $past(irq_count) - 8'd1)
    else $error("scanline tick did not decrement the irq counter");

endmodule
